@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the stack calculator RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every rising clock edge outside reset
`define RSC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define RSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define RSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rsc_pkg.sv @@
// Shared constants, codes and control/status structs of the RPN stack calculator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 5;
  localparam int KIND_W      = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STACK_DEPTH);

  // Operation codes
  localparam logic [FUNC_W-1:0] F_PUSH     = 5'd0;
  localparam logic [FUNC_W-1:0] F_PRINT    = 5'd1;
  localparam logic [FUNC_W-1:0] F_PRINTPOP = 5'd2;
  localparam logic [FUNC_W-1:0] F_DUMP     = 5'd3;
  localparam logic [FUNC_W-1:0] F_CLEAR    = 5'd4;
  localparam logic [FUNC_W-1:0] F_SWAP     = 5'd5;
  localparam logic [FUNC_W-1:0] F_DUP      = 5'd6;
  localparam logic [FUNC_W-1:0] F_DEPTH    = 5'd7;
  localparam logic [FUNC_W-1:0] F_ROT      = 5'd8;
  localparam logic [FUNC_W-1:0] F_NIP      = 5'd9;
  localparam logic [FUNC_W-1:0] F_NEG      = 5'd10;
  localparam logic [FUNC_W-1:0] F_TUCK     = 5'd11;
  localparam logic [FUNC_W-1:0] F_OVER     = 5'd12;
  localparam logic [FUNC_W-1:0] F_DROP     = 5'd13;
  localparam logic [FUNC_W-1:0] F_ADD      = 5'd14;
  localparam logic [FUNC_W-1:0] F_SUB      = 5'd15;
  localparam logic [FUNC_W-1:0] F_MUL      = 5'd16;
  localparam logic [FUNC_W-1:0] F_DIV      = 5'd17;
  localparam logic [FUNC_W-1:0] F_POW      = 5'd18;
  localparam logic [FUNC_W-1:0] F_QUIT     = 5'd19;
  localparam logic [FUNC_W-1:0] F_NOP      = 5'd20;
  localparam logic [FUNC_W-1:0] F_UNKNOWN  = 5'd21;

  // Result kinds
  localparam logic [KIND_W-1:0] K_VALUE = 3'd0;
  localparam logic [KIND_W-1:0] K_DEPTH = 3'd1;
  localparam logic [KIND_W-1:0] K_UNDER = 3'd2;
  localparam logic [KIND_W-1:0] K_OVER  = 3'd3;
  localparam logic [KIND_W-1:0] K_DIVZ  = 3'd4;
  localparam logic [KIND_W-1:0] K_NIMP  = 3'd5;

  // Read address select
  localparam logic [1:0] RA_B    = 2'd0;  // count-1
  localparam logic [1:0] RA_A    = 2'd1;  // count-2
  localparam logic [1:0] RA_X    = 2'd2;  // count-3
  localparam logic [1:0] RA_WALK = 2'd3;  // dump index

  // Write address select
  localparam logic [1:0] WA_C = 2'd0;     // count
  localparam logic [1:0] WA_B = 2'd1;     // count-1
  localparam logic [1:0] WA_A = 2'd2;     // count-2
  localparam logic [1:0] WA_X = 2'd3;     // count-3

  // Write data select
  localparam logic [2:0] WD_PV    = 3'd0;
  localparam logic [2:0] WD_A     = 3'd1;
  localparam logic [2:0] WD_B     = 3'd2;
  localparam logic [2:0] WD_X     = 3'd3;
  localparam logic [2:0] WD_DEPTH = 3'd4;
  localparam logic [2:0] WD_RES   = 3'd5;
  localparam logic [2:0] WD_NEG   = 3'd6;

  // Entry count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // Result value source
  localparam logic [1:0] OS_ZERO  = 2'd0;
  localparam logic [1:0] OS_B     = 2'd1;
  localparam logic [1:0] OS_DEPTH = 2'd2;
  localparam logic [1:0] OS_RD    = 2'd3;

  // Arithmetic unit operations
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_MUL = 3'd2;
  localparam logic [2:0] ALU_DIV = 3'd3;
  localparam logic [2:0] ALU_POW = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic              take_in;
    logic [1:0]        rd_sel;
    logic              cap_b;
    logic              cap_a;
    logic              cap_x;
    logic              wr_en;
    logic [1:0]        wr_sel;
    logic [2:0]        wd_sel;
    logic [1:0]        cnt_op;
    logic              walk_init;
    logic              walk_dec;
    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic [1:0]        out_src;
    logic              out_last;
    logic              alu_start;
    logic [2:0]        alu_op;
  } dp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             walk_zero;
    logic             out_free;
    logic             alu_done;
    logic             alu_divz;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator on Q16.16 numbers.
// Depends on rsc_pkg, rsc_ctrl and rsc_dp (which holds rsc_ram and rsc_alu).
//
// Command channel (cmd_valid/cmd_stall, func, push_value): one word per
// operation. cmd_stall is low only while the block is idle, so one command
// is in flight at a time.
// Result channel (rsp_valid/rsp_stall, kind, result_value, last): a print,
// an error or each word of a dump; last marks the final word of a command.
// Push, push-depth, clear, drop, quit and no-op complete in decode when no error
// is found. Print, stack shuffles and arithmetic first read the top entries.
// div uses a 48-step restoring divider; pow runs 16 square-and-multiply rounds
// on the one shared multiplier, then the divider for the reciprocal of a
// negative exponent. A dump reads the stack RAM one entry at a time.
// A stalled result word holds in the output register; the controller waits
// for it before loading the next word.
// Reset empties the stack, clears the halt flag and drops any pending word;
// stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output      logic                       cmd_stall,
  input  wire logic [rsc_pkg::FUNC_W-1:0] func,
  input  wire logic [rsc_pkg::DATA_W-1:0] push_value,
  output      logic                       rsp_valid,
  input  wire logic                       rsp_stall,
  output      logic [rsc_pkg::KIND_W-1:0] kind,
  output      logic [rsc_pkg::DATA_W-1:0] result_value,
  output      logic                       last
);

  rsc_pkg::dp_ctl_t ctl;
  rsc_pkg::dp_sts_t sts;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .ctl       (ctl),
    .sts       (sts)
  );

  rsc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .push_value   (push_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .kind         (kind),
    .result_value (result_value),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ rtl/core/rsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/rsc_alu.sv @@
// Multi-cycle Q16.16 arithmetic unit: saturating add/sub, mul, restoring divide, pow.
// Depends on rsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsc_alu (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [2:0]                op,
  input  wire logic [rsc_pkg::DATA_W-1:0] a,
  input  wire logic [rsc_pkg::DATA_W-1:0] b,
  output      logic                      done,
  output      logic                      divz,
  output      logic [rsc_pkg::DATA_W-1:0] res
);

  localparam logic [3:0] A_IDLE = 4'd0;
  localparam logic [3:0] A_MUL1 = 4'd1;
  localparam logic [3:0] A_MUL2 = 4'd2;
  localparam logic [3:0] A_DIV  = 4'd3;
  localparam logic [3:0] A_DFIN = 4'd4;
  localparam logic [3:0] A_PACC = 4'd5;
  localparam logic [3:0] A_PSQ  = 4'd6;
  localparam logic [3:0] A_PSB  = 4'd7;
  localparam logic [3:0] A_PFIN = 4'd8;
  localparam logic [3:0] A_DONE = 4'd9;

  logic [3:0]  st;
  logic        sign_r;
  logic        inv;
  logic [31:0] acc;
  logic [31:0] base;
  logic [15:0] expo;
  logic [3:0]  idx;
  logic [47:0] dvd;
  logic [31:0] den;
  logic [31:0] rem;
  logic [5:0]  step;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;

  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] sum;
  logic [32:0] dif;
  logic [15:0] nexp;
  logic [15:0] eabs;
  logic [32:0] rem_sh;
  logic        ge;

  // Saturating conversion of a sign and magnitude to Q16.16
  function automatic logic [31:0] from_mag(input logic neg, input logic [47:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m >= 48'h0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end else begin
      r = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  // Truncated product held at 2^31
  function automatic logic [31:0] cap(input logic [47:0] q);
    return (q > 48'h0000_8000_0000) ? 32'h8000_0000 : q[31:0];
  endfunction

  // Operand magnitudes, sums, exponent, divider compare and done flag
  always_comb begin
    ma     = a[31] ? (~a + 32'd1) : a;
    mb     = b[31] ? (~b + 32'd1) : b;
    sum    = {a[31], a} + {b[31], b};
    dif    = {a[31], a} - {b[31], b};
    // truncate toward zero
    nexp   = (b[31] && (b[15:0] != 16'd0)) ? (b[31:16] + 16'd1) : b[31:16];
    eabs   = nexp[15] ? (~nexp + 16'd1) : nexp;
    rem_sh = {rem, dvd[47]};
    ge     = (rem_sh >= {1'b0, den});
    done   = (st == A_DONE);
  end

  // Shared multiplier operand select
  always_comb begin
    case (st)
      A_PACC: begin
        mul_x = acc;
        mul_y = base;
      end
      A_PSQ: begin
        mul_x = base;
        mul_y = base;
      end
      default: begin
        mul_x = acc;
        mul_y = base;
      end
    endcase
  end

  // Registered product
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      divz <= 1'b0;
    end else begin
      case (st)
        A_IDLE: begin
          if (start) begin
            divz <= 1'b0;
            case (op)
              rsc_pkg::ALU_ADD: begin
                res <= (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : sum[31:0];
                st  <= A_DONE;
              end
              rsc_pkg::ALU_SUB: begin
                res <= (dif[32] != dif[31]) ? (dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : dif[31:0];
                st  <= A_DONE;
              end
              rsc_pkg::ALU_MUL: begin
                sign_r <= a[31] ^ b[31];
                acc    <= ma;
                base   <= mb;
                st     <= A_MUL1;
              end
              rsc_pkg::ALU_DIV: begin
                if (b == 32'd0) begin
                  divz <= 1'b1;
                  st   <= A_DONE;
                end else begin
                  sign_r <= a[31] ^ b[31];
                  dvd    <= {ma, 16'd0};
                  den    <= mb;
                  rem    <= 32'd0;
                  step   <= 6'd0;
                  st     <= A_DIV;
                end
              end
              rsc_pkg::ALU_POW: begin
                if (nexp[15] && (a == 32'd0)) begin
                  divz <= 1'b1;
                  st   <= A_DONE;
                end else begin
                  inv    <= nexp[15];
                  sign_r <= a[31] & eabs[0];
                  acc    <= 32'h0001_0000;
                  base   <= ma;
                  expo   <= eabs;
                  idx    <= 4'd0;
                  st     <= A_PACC;
                end
              end
              default: begin
                st <= A_DONE;
              end
            endcase
          end
        end
        A_MUL1: st <= A_MUL2;
        A_MUL2: begin
          res <= from_mag(sign_r, prod[63:16]);
          st  <= A_DONE;
        end
        // one quotient bit a cycle
        A_DIV: begin
          rem  <= ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
          dvd  <= {dvd[46:0], ge};
          step <= step + 6'd1;
          if (step == 6'd47) begin
            st <= A_DFIN;
          end
        end
        A_DFIN: begin
          res <= from_mag(sign_r, dvd);
          st  <= A_DONE;
        end
        // square-and-multiply, one exponent bit per pass through A_PACC, A_PSQ and A_PSB
        A_PACC: st <= A_PSQ;
        A_PSQ: begin
          if (expo[idx]) begin
            acc <= cap(prod[63:16]);
          end
          st <= A_PSB;
        end
        A_PSB: begin
          base <= cap(prod[63:16]);
          idx  <= idx + 4'd1;
          st   <= (idx == 4'd15) ? A_PFIN : A_PACC;
        end
        A_PFIN: begin
          if (!inv) begin
            res <= from_mag(sign_r, {16'd0, acc});
            st  <= A_DONE;
          end else if (acc == 32'd0) begin
            res <= from_mag(sign_r, 48'h0000_8000_0000);
            st  <= A_DONE;
          end else begin
            dvd  <= 48'h0001_0000_0000;
            den  <= acc;
            rem  <= 32'd0;
            step <= 6'd0;
            st   <= A_DIV;
          end
        end
        A_DONE: st <= A_IDLE;
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rsc_dp.sv @@
// Datapath: stack RAM, entry count, operand registers, arithmetic unit, result register.
// Depends on rsc_pkg, rsc_ram, rsc_alu and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsc_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rsc_pkg::dp_ctl_t           ctl,
  output      rsc_pkg::dp_sts_t           sts,
  input  wire logic [rsc_pkg::DATA_W-1:0] push_value,
  output      logic                       rsp_valid,
  input  wire logic                       rsp_stall,
  output      logic [rsc_pkg::KIND_W-1:0] kind,
  output      logic [rsc_pkg::DATA_W-1:0] result_value,
  output      logic                       last
);

  logic [rsc_pkg::DATA_W-1:0] pv_r;
  logic [rsc_pkg::DATA_W-1:0] a_r;
  logic [rsc_pkg::DATA_W-1:0] b_r;
  logic [rsc_pkg::DATA_W-1:0] x_r;
  logic [rsc_pkg::CNT_W-1:0]  cnt;
  logic [rsc_pkg::PTR_W-1:0]  walk;

  logic [rsc_pkg::CNT_W-1:0]  cnt_m1;
  logic [rsc_pkg::CNT_W-1:0]  cnt_m2;
  logic [rsc_pkg::CNT_W-1:0]  cnt_m3;
  logic [rsc_pkg::PTR_W-1:0]  rd_addr;
  logic [rsc_pkg::PTR_W-1:0]  wr_addr;
  logic [rsc_pkg::DATA_W-1:0] wr_data;
  logic [rsc_pkg::DATA_W-1:0] rd_data;
  logic [rsc_pkg::DATA_W-1:0] depth_q;
  logic [rsc_pkg::DATA_W-1:0] neg_b;
  logic [rsc_pkg::DATA_W-1:0] alu_res;
  logic                       alu_done;
  logic                       alu_divz;
  logic                       out_free;

  // Address arithmetic on the entry count, depth word, negation and output-free flag
  always_comb begin
    cnt_m1   = cnt - rsc_pkg::CNT_W'(1);
    cnt_m2   = cnt - rsc_pkg::CNT_W'(2);
    cnt_m3   = cnt - rsc_pkg::CNT_W'(3);
    depth_q  = rsc_pkg::DATA_W'(cnt) << 16;
    neg_b    = (b_r == 32'h8000_0000) ? 32'h7FFF_FFFF : (~b_r + 32'd1);
    out_free = !rsp_valid || !rsp_stall;
  end

  // Read address
  always_comb begin
    case (ctl.rd_sel)
      rsc_pkg::RA_B: rd_addr = cnt_m1[rsc_pkg::PTR_W-1:0];
      rsc_pkg::RA_A: rd_addr = cnt_m2[rsc_pkg::PTR_W-1:0];
      rsc_pkg::RA_X: rd_addr = cnt_m3[rsc_pkg::PTR_W-1:0];
      default:       rd_addr = walk;
    endcase
  end

  // Write address and data
  always_comb begin
    case (ctl.wr_sel)
      rsc_pkg::WA_C: wr_addr = cnt[rsc_pkg::PTR_W-1:0];
      rsc_pkg::WA_B: wr_addr = cnt_m1[rsc_pkg::PTR_W-1:0];
      rsc_pkg::WA_A: wr_addr = cnt_m2[rsc_pkg::PTR_W-1:0];
      default:       wr_addr = cnt_m3[rsc_pkg::PTR_W-1:0];
    endcase
    case (ctl.wd_sel)
      rsc_pkg::WD_PV:    wr_data = pv_r;
      rsc_pkg::WD_A:     wr_data = a_r;
      rsc_pkg::WD_B:     wr_data = b_r;
      rsc_pkg::WD_X:     wr_data = x_r;
      rsc_pkg::WD_DEPTH: wr_data = depth_q;
      rsc_pkg::WD_RES:   wr_data = alu_res;
      default:           wr_data = neg_b;
    endcase
  end

  rsc_ram #(
    .WIDTH (rsc_pkg::DATA_W),
    .DEPTH (rsc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsc_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.alu_start),
    .op    (ctl.alu_op),
    .a     (a_r),
    .b     (b_r),
    .done  (alu_done),
    .divz  (alu_divz),
    .res   (alu_res)
  );

  // Operand and input registers and dump walk pointer
  always_ff @(posedge clk) begin
    if (ctl.take_in) pv_r <= push_value;
    if (ctl.cap_b)   b_r  <= rd_data;
    if (ctl.cap_a)   a_r  <= rd_data;
    if (ctl.cap_x)   x_r  <= rd_data;
    if (ctl.walk_init) begin
      walk <= cnt_m1[rsc_pkg::PTR_W-1:0];
    end else if (ctl.walk_dec) begin
      walk <= walk - rsc_pkg::PTR_W'(1);
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (ctl.cnt_op)
        rsc_pkg::CNT_INC: cnt <= cnt + rsc_pkg::CNT_W'(1);
        rsc_pkg::CNT_DEC: cnt <= cnt_m1;
        rsc_pkg::CNT_CLR: cnt <= '0;
        default:          cnt <= cnt;
      endcase
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      kind <= ctl.out_kind;
      last <= ctl.out_last;
      case (ctl.out_src)
        rsc_pkg::OS_B:     result_value <= b_r;
        rsc_pkg::OS_DEPTH: result_value <= rsc_pkg::DATA_W'(cnt);
        rsc_pkg::OS_RD:    result_value <= rd_data;
        default:           result_value <= '0;
      endcase
    end
  end

  always_comb begin
    sts.cnt       = cnt;
    sts.walk_zero = (walk == '0);
    sts.out_free  = out_free;
    sts.alu_done  = alu_done;
    sts.alu_divz  = alu_divz;
  end

  `RSC_ASSERT(a_cnt_range, cnt <= rsc_pkg::CNT_MAX, "entry count beyond stack depth")
  `RSC_ASSERT_IMP(a_inc_room, ctl.cnt_op == rsc_pkg::CNT_INC, cnt < rsc_pkg::CNT_MAX, "push on full stack")
  `RSC_ASSERT_IMP(a_load_free, ctl.out_load, out_free, "result register overwritten")

endmodule

`default_nettype wire

@@ rtl/core/rsc_ctrl.sv @@
// Controller: decodes each operation, checks errors and sequences the datapath.
// Depends on rsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output      logic                       cmd_stall,
  input  wire logic [rsc_pkg::FUNC_W-1:0] func,
  output      rsc_pkg::dp_ctl_t           ctl,
  input  wire rsc_pkg::dp_sts_t           sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_ERR  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_RD3  = 4'd6;
  localparam logic [3:0] S_EXEC = 4'd7;
  localparam logic [3:0] S_WR1  = 4'd8;
  localparam logic [3:0] S_WR2  = 4'd9;
  localparam logic [3:0] S_ALU  = 4'd10;
  localparam logic [3:0] S_DHD  = 4'd11;
  localparam logic [3:0] S_DRD  = 4'd12;
  localparam logic [3:0] S_DOUT = 4'd13;

  logic [3:0]                 state;
  logic [3:0]                 state_next;
  logic [rsc_pkg::FUNC_W-1:0] func_r;
  logic [rsc_pkg::KIND_W-1:0] kind_r;
  logic [rsc_pkg::KIND_W-1:0] kind_next;
  logic                       halted;
  logic                       halted_next;
  logic [1:0]                 need;
  logic                       grow;

  // Entries each operation needs, and whether it grows the stack
  always_comb begin
    case (func_r)
      rsc_pkg::F_PRINT, rsc_pkg::F_PRINTPOP, rsc_pkg::F_DUP, rsc_pkg::F_NEG,
      rsc_pkg::F_DROP: need = 2'd1;
      rsc_pkg::F_SWAP, rsc_pkg::F_NIP, rsc_pkg::F_TUCK, rsc_pkg::F_OVER,
      rsc_pkg::F_ADD, rsc_pkg::F_SUB, rsc_pkg::F_MUL, rsc_pkg::F_DIV,
      rsc_pkg::F_POW: need = 2'd2;
      rsc_pkg::F_ROT: need = 2'd3;
      default: need = 2'd0;
    endcase
    grow = (func_r == rsc_pkg::F_PUSH) || (func_r == rsc_pkg::F_DUP) ||
           (func_r == rsc_pkg::F_DEPTH) || (func_r == rsc_pkg::F_TUCK) ||
           (func_r == rsc_pkg::F_OVER);
  end

  // Next state and datapath commands
  always_comb begin
    state_next  = state;
    kind_next   = kind_r;
    halted_next = halted;
    ctl         = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.take_in = 1'b1;
          if (!halted) state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (func_r >= rsc_pkg::F_UNKNOWN) begin
          kind_next  = rsc_pkg::K_NIMP;
          state_next = S_ERR;
        end else if (sts.cnt < rsc_pkg::CNT_W'(need)) begin
          kind_next  = rsc_pkg::K_UNDER;
          state_next = S_ERR;
        end else if (grow && (sts.cnt >= rsc_pkg::CNT_MAX)) begin
          kind_next  = rsc_pkg::K_OVER;
          state_next = S_ERR;
        end else begin
          case (func_r)
            rsc_pkg::F_PUSH: begin
              ctl.wr_en  = 1'b1;
              ctl.wr_sel = rsc_pkg::WA_C;
              ctl.wd_sel = rsc_pkg::WD_PV;
              ctl.cnt_op = rsc_pkg::CNT_INC;
              state_next = S_IDLE;
            end
            rsc_pkg::F_DEPTH: begin
              ctl.wr_en  = 1'b1;
              ctl.wr_sel = rsc_pkg::WA_C;
              ctl.wd_sel = rsc_pkg::WD_DEPTH;
              ctl.cnt_op = rsc_pkg::CNT_INC;
              state_next = S_IDLE;
            end
            rsc_pkg::F_CLEAR: begin
              ctl.cnt_op = rsc_pkg::CNT_CLR;
              state_next = S_IDLE;
            end
            rsc_pkg::F_DROP: begin
              ctl.cnt_op = rsc_pkg::CNT_DEC;
              state_next = S_IDLE;
            end
            rsc_pkg::F_QUIT: begin
              halted_next = 1'b1;
              state_next  = S_IDLE;
            end
            rsc_pkg::F_NOP:  state_next = S_IDLE;
            rsc_pkg::F_DUMP: state_next = S_DHD;
            default:         state_next = S_RD0;
          endcase
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = kind_r;
          ctl.out_src  = rsc_pkg::OS_ZERO;
          ctl.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // fetch top three entries, one read a cycle
      S_RD0: begin
        ctl.rd_sel = rsc_pkg::RA_B;
        state_next = S_RD1;
      end
      S_RD1: begin
        ctl.cap_b  = 1'b1;
        ctl.rd_sel = rsc_pkg::RA_A;
        state_next = S_RD2;
      end
      S_RD2: begin
        ctl.cap_a  = 1'b1;
        ctl.rd_sel = rsc_pkg::RA_X;
        state_next = S_RD3;
      end
      S_RD3: begin
        ctl.cap_x  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (func_r)
          rsc_pkg::F_PRINT, rsc_pkg::F_PRINTPOP: begin
            if (sts.out_free) begin
              ctl.out_load = 1'b1;
              ctl.out_kind = rsc_pkg::K_VALUE;
              ctl.out_src  = rsc_pkg::OS_B;
              ctl.out_last = 1'b1;
              if (func_r == rsc_pkg::F_PRINTPOP) ctl.cnt_op = rsc_pkg::CNT_DEC;
            end else begin
              state_next = S_EXEC;
            end
          end
          rsc_pkg::F_SWAP: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_B;
            ctl.wd_sel = rsc_pkg::WD_A;
            state_next = S_WR1;
          end
          rsc_pkg::F_DUP: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_C;
            ctl.wd_sel = rsc_pkg::WD_B;
            ctl.cnt_op = rsc_pkg::CNT_INC;
          end
          rsc_pkg::F_ROT: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_X;
            ctl.wd_sel = rsc_pkg::WD_A;
            state_next = S_WR1;
          end
          rsc_pkg::F_NIP: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_A;
            ctl.wd_sel = rsc_pkg::WD_B;
            ctl.cnt_op = rsc_pkg::CNT_DEC;
          end
          rsc_pkg::F_NEG: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_B;
            ctl.wd_sel = rsc_pkg::WD_NEG;
          end
          rsc_pkg::F_TUCK: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_A;
            ctl.wd_sel = rsc_pkg::WD_B;
            state_next = S_WR1;
          end
          rsc_pkg::F_OVER: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_C;
            ctl.wd_sel = rsc_pkg::WD_A;
            ctl.cnt_op = rsc_pkg::CNT_INC;
          end
          rsc_pkg::F_ADD: begin
            ctl.alu_start = 1'b1;
            ctl.alu_op    = rsc_pkg::ALU_ADD;
            state_next    = S_ALU;
          end
          rsc_pkg::F_SUB: begin
            ctl.alu_start = 1'b1;
            ctl.alu_op    = rsc_pkg::ALU_SUB;
            state_next    = S_ALU;
          end
          rsc_pkg::F_MUL: begin
            ctl.alu_start = 1'b1;
            ctl.alu_op    = rsc_pkg::ALU_MUL;
            state_next    = S_ALU;
          end
          rsc_pkg::F_DIV: begin
            ctl.alu_start = 1'b1;
            ctl.alu_op    = rsc_pkg::ALU_DIV;
            state_next    = S_ALU;
          end
          rsc_pkg::F_POW: begin
            ctl.alu_start = 1'b1;
            ctl.alu_op    = rsc_pkg::ALU_POW;
            state_next    = S_ALU;
          end
          default: state_next = S_IDLE;
        endcase
      end
      // second write of swap, rotate and tuck
      S_WR1: begin
        ctl.wr_en  = 1'b1;
        state_next = S_IDLE;
        case (func_r)
          rsc_pkg::F_SWAP: begin
            ctl.wr_sel = rsc_pkg::WA_A;
            ctl.wd_sel = rsc_pkg::WD_B;
          end
          rsc_pkg::F_ROT: begin
            ctl.wr_sel = rsc_pkg::WA_A;
            ctl.wd_sel = rsc_pkg::WD_B;
            state_next = S_WR2;
          end
          rsc_pkg::F_TUCK: begin
            ctl.wr_sel = rsc_pkg::WA_B;
            ctl.wd_sel = rsc_pkg::WD_A;
            state_next = S_WR2;
          end
          default: ctl.wr_en = 1'b0;
        endcase
      end
      // third write of rotate and tuck
      S_WR2: begin
        ctl.wr_en  = 1'b1;
        state_next = S_IDLE;
        case (func_r)
          rsc_pkg::F_ROT: begin
            ctl.wr_sel = rsc_pkg::WA_B;
            ctl.wd_sel = rsc_pkg::WD_X;
          end
          rsc_pkg::F_TUCK: begin
            ctl.wr_sel = rsc_pkg::WA_C;
            ctl.wd_sel = rsc_pkg::WD_B;
            ctl.cnt_op = rsc_pkg::CNT_INC;
          end
          default: ctl.wr_en = 1'b0;
        endcase
      end
      S_ALU: begin
        if (sts.alu_done) begin
          if (sts.alu_divz) begin
            kind_next  = rsc_pkg::K_DIVZ;
            state_next = S_ERR;
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = rsc_pkg::WA_A;
            ctl.wd_sel = rsc_pkg::WD_RES;
            ctl.cnt_op = rsc_pkg::CNT_DEC;
            state_next = S_IDLE;
          end
        end
      end
      // dump: depth word, then entries top down
      S_DHD: begin
        if (sts.out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_kind  = rsc_pkg::K_DEPTH;
          ctl.out_src   = rsc_pkg::OS_DEPTH;
          ctl.out_last  = (sts.cnt == '0);
          ctl.walk_init = 1'b1;
          state_next    = (sts.cnt == '0) ? S_IDLE : S_DRD;
        end
      end
      S_DRD: begin
        ctl.rd_sel = rsc_pkg::RA_WALK;
        state_next = S_DOUT;
      end
      S_DOUT: begin
        ctl.rd_sel = rsc_pkg::RA_WALK;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = rsc_pkg::K_VALUE;
          ctl.out_src  = rsc_pkg::OS_RD;
          ctl.out_last = sts.walk_zero;
          if (sts.walk_zero) begin
            state_next = S_IDLE;
          end else begin
            ctl.walk_dec = 1'b1;
            state_next   = S_DRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      halted <= 1'b0;
      kind_r <= rsc_pkg::K_VALUE;
    end else begin
      state  <= state_next;
      halted <= halted_next;
      kind_r <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid) func_r <= func;
  end

  `RSC_ASSERT_NXT(a_halt_sticky, halted, halted, "halt flag cleared outside reset")

endmodule

`default_nettype wire

@@ verif/rpn_stack_calculator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator: directed and random command words,
// scored against a behavioural stack model kept in the bench. Depends on rsc_pkg.
module rpn_stack_calculator_tb;
  import rsc_pkg::*;

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  logic [FUNC_W-1:0]   func;
  logic [DATA_W-1:0]   push_value;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [KIND_W-1:0]   kind;
  logic [DATA_W-1:0]   result_value;
  logic                last;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } rsp_word_t;

  rsp_word_t               pending_words[$];
  logic signed [DATA_W-1:0] stk_mem[STACK_DEPTH];
  int                      stk_cnt;
  bit                      stk_halted;
  int                      errors;
  int                      send_idle_pct;
  int                      rsp_stall_pct;

  localparam longint unsigned CAP = 64'h8000_0000;
  localparam int              DRAIN_CYCLES = 160;

  rpn_stack_calculator u_dut (
    .clk, .rst, .cmd_valid, .cmd_stall, .func, .push_value,
    .rsp_valid, .rsp_stall, .kind, .result_value, .last
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Q16.16 helpers
  function automatic logic signed [31:0] sat64(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned mag(logic signed [31:0] v);
    longint sv;
    sv = v;
    return (sv < 0) ? longint'(-sv) : longint'(sv);
  endfunction

  function automatic logic signed [31:0] from_mag(bit neg, longint unsigned m);
    if (neg) begin
      if (m >= CAP) return 32'sh8000_0000;
      return -longint'(m);
    end
    if (m > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic longint unsigned umul_cap(longint unsigned x, longint unsigned y);
    longint unsigned q;
    q = (x * y) >> 16;
    return (q > CAP) ? CAP : q;
  endfunction

  function automatic void add_word(logic [KIND_W-1:0] k, logic [31:0] v, logic l);
    rsp_word_t w;
    w.kind = k;
    w.value = v;
    w.last = l;
    pending_words.push_back(w);
  endfunction

  // Stack model: update state and queue the words a command produces
  function automatic void model_cmd(logic [FUNC_W-1:0] f, logic signed [31:0] pv);
    int need;
    bit grow;
    logic signed [31:0] a, b, t;
    longint n;
    longint unsigned e, base, acc;
    int c;
    need = 0;
    grow = 0;
    a = 0;
    b = 0;
    c = stk_cnt;
    if (stk_halted) return;
    case (f)
      F_PRINT, F_PRINTPOP, F_DUP, F_NEG, F_DROP: need = 1;
      F_SWAP, F_NIP, F_TUCK, F_OVER, F_ADD, F_SUB, F_MUL, F_DIV, F_POW: need = 2;
      F_ROT: need = 3;
      default: need = 0;
    endcase
    grow = (f == F_PUSH || f == F_DUP || f == F_DEPTH || f == F_TUCK || f == F_OVER);
    if (f >= F_UNKNOWN) begin
      add_word(K_NIMP, 0, 1'b1);
      return;
    end
    if (c < need) begin
      add_word(K_UNDER, 0, 1'b1);
      return;
    end
    if (grow && c >= STACK_DEPTH) begin
      add_word(K_OVER, 0, 1'b1);
      return;
    end
    if (c >= 1) b = stk_mem[c-1];
    if (c >= 2) a = stk_mem[c-2];
    case (f)
      F_PUSH: begin stk_mem[c] = pv; stk_cnt = c + 1; end
      F_PRINT: add_word(K_VALUE, b, 1'b1);
      F_PRINTPOP: begin add_word(K_VALUE, b, 1'b1); stk_cnt = c - 1; end
      F_DUMP: begin
        add_word(K_DEPTH, c, c == 0);
        for (int k = c - 1; k >= 0; k--) add_word(K_VALUE, stk_mem[k], k == 0);
      end
      F_CLEAR: stk_cnt = 0;
      F_SWAP: begin stk_mem[c-1] = a; stk_mem[c-2] = b; end
      F_DUP: begin stk_mem[c] = b; stk_cnt = c + 1; end
      F_DEPTH: begin stk_mem[c] = c << 16; stk_cnt = c + 1; end
      F_ROT: begin
        t = stk_mem[c-3];
        stk_mem[c-3] = a; stk_mem[c-2] = b; stk_mem[c-1] = t;
      end
      F_NIP: begin stk_mem[c-2] = b; stk_cnt = c - 1; end
      F_NEG: stk_mem[c-1] = sat64(-longint'(b));
      F_TUCK: begin
        stk_mem[c-2] = b; stk_mem[c-1] = a; stk_mem[c] = b; stk_cnt = c + 1;
      end
      F_OVER: begin stk_mem[c] = a; stk_cnt = c + 1; end
      F_DROP: stk_cnt = c - 1;
      F_ADD: begin stk_mem[c-2] = sat64(longint'(a) + longint'(b)); stk_cnt = c - 1; end
      F_SUB: begin stk_mem[c-2] = sat64(longint'(a) - longint'(b)); stk_cnt = c - 1; end
      F_MUL: begin
        stk_mem[c-2] = from_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 16);
        stk_cnt = c - 1;
      end
      F_DIV: begin
        if (b == 0) add_word(K_DIVZ, 0, 1'b1);
        else begin
          stk_mem[c-2] = from_mag((a < 0) != (b < 0), (mag(a) << 16) / mag(b));
          stk_cnt = c - 1;
        end
      end
      F_POW: begin
        n = longint'(b) / 65536;
        e = (n < 0) ? longint'(-n) : longint'(n);
        if (n < 0 && a == 0) add_word(K_DIVZ, 0, 1'b1);
        else begin
          // square-and-multiply on magnitudes, integer exponent only
          base = mag(a);
          acc = 64'h1_0000;
          for (int i = 0; i < 16; i++) begin
            if (e[i]) acc = umul_cap(acc, base);
            base = umul_cap(base, base);
          end
          if (n < 0) acc = (acc == 0) ? CAP : (64'h1_0000_0000 / acc);
          stk_mem[c-2] = from_mag((a < 0) && e[0], acc);
          stk_cnt = c - 1;
        end
      end
      F_QUIT: stk_halted = 1'b1;
      default: ;
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    rsp_word_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0d value=%h last=%b",
                 $time, kind, result_value, last);
      end else begin
        w = pending_words.pop_front();
        if (kind !== w.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
        end
        if (result_value !== w.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, w.value, result_value);
        end
        if (last !== w.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, w.last, last);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_stall = (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
  end

  // Drive one command word and wait for it to be taken
  task automatic send_cmd(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid = 1'b1;
    func = f;
    push_value = v;
    do @(posedge clk); while (cmd_stall);
    model_cmd(f, v);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return (($urandom_range(16) - 8) << 16) | $urandom_range(16'hFFFF);
      2: case ($urandom_range(4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h0001_0000;
           default: return 32'hFFFF_0000;
         endcase
      3: return $urandom_range(32'h2_FFFF) ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
      default: return ($urandom_range(6) - 3) << 16;
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(F_DUMP, 0);
    send_cmd(F_PRINT, 0);
    send_cmd(F_PUSH, 32'h7FFF_FFFF);
    send_cmd(F_SWAP, 0);
    send_cmd(F_PUSH, 32'h8000_0000);
    send_cmd(F_ADD, 0);
    send_cmd(F_PRINT, 0);
    send_cmd(F_PUSH, 32'h0);
    send_cmd(F_DIV, 0);
    send_cmd(F_PUSH, 32'h0001_0000);
    send_cmd(F_MUL, 0);
    send_cmd(F_PRINTPOP, 0);
    send_cmd(F_PUSH, 32'h0002_0000);
    send_cmd(F_PUSH, 32'hFFFE_8000);
    send_cmd(F_POW, 0);
    send_cmd(F_PUSH, 32'h0003_0000);
    send_cmd(F_ROT, 0);
    send_cmd(F_NEG, 0);
    send_cmd(F_TUCK, 0);
    send_cmd(F_OVER, 0);
    send_cmd(F_DUP, 0);
    send_cmd(F_DEPTH, 0);
    send_cmd(F_NIP, 0);
    send_cmd(F_SUB, 0);
    send_cmd(F_DROP, 0);
    send_cmd(F_NOP, 0);
    send_cmd(F_DUMP, 0);
    send_cmd(F_CLEAR, 0);
    send_cmd(F_ROT, 0);
    // 0 to a negative power, and every unimplemented code
    send_cmd(F_PUSH, 0);
    send_cmd(F_PUSH, 32'hFFFF_0000);
    send_cmd(F_POW, 0);
    for (int f = F_UNKNOWN; f < (1 << FUNC_W); f++) send_cmd(f, $urandom);
    send_cmd(F_CLEAR, 0);
  endtask

  // Fill the stack and hit every overflow path
  task automatic test_overflow();
    while (stk_cnt < STACK_DEPTH) send_cmd(F_PUSH, rand_value());
    send_cmd(F_PUSH, 32'h1234_5678);
    send_cmd(F_DUP, 0);
    send_cmd(F_DEPTH, 0);
    send_cmd(F_TUCK, 0);
    send_cmd(F_OVER, 0);
    send_cmd(F_DUMP, 0);
    send_cmd(F_CLEAR, 0);
  endtask

  task automatic test_random(int items, int idle_pct, int stall_pct);
    int r;
    logic [FUNC_W-1:0] f;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < ((stk_cnt < 3) ? 55 : 30)) f = F_PUSH;
      else if (r < 97) begin
        f = $urandom_range(F_POW, F_PRINT);
        if (f == F_CLEAR && $urandom_range(3) != 0) f = F_PUSH;
        if (f == F_DUMP && $urandom_range(1) != 0) f = F_PRINT;
      end else if (r < 98) f = F_NOP;
      else f = $urandom_range((1 << FUNC_W) - 1, F_UNKNOWN);
      send_cmd(f, rand_value());
    end
    drain();
  endtask

  // After quit nothing may respond
  task automatic test_quit();
    send_cmd(F_PUSH, 32'h0005_0000);
    send_cmd(F_QUIT, 0);
    send_cmd(F_PRINT, 0);
    send_cmd(F_DUMP, 0);
    send_cmd(F_UNKNOWN, 0);
    send_cmd(F_DROP, 0);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    func = '0;
    push_value = '0;
    rsp_stall = 1'b0;
    errors = 0;
    stk_cnt = 0;
    stk_halted = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_overflow();
    drain();
    test_random(80, 0, 0);
    test_random(80, 77, 0);
    test_random(80, 0, 77);
    test_random(80, 25, 25);
    test_quit();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rsc_pkg.sv
rtl/core/rsc_ram.sv
rtl/core/rsc_alu.sv
rtl/core/rsc_dp.sv
rtl/core/rsc_ctrl.sv
rtl/core/rpn_stack_calculator.sv
verif/rpn_stack_calculator_tb.sv
